[rtl/assert_macros.svh]
// Assertion macros included by trilateration_solver.sv, which checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TRILAT_ASSERT_IMP(lbl, clk, rst_n, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
		else $error("implication check failed");

`define TRILAT_ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
		else $error("next-cycle check failed");

`else

`define TRILAT_ASSERT_IMP(lbl, clk, rst_n, ant, con)

`define TRILAT_ASSERT_NEXT(lbl, clk, rst_n, ant, con)

`endif

`endif

[rtl/trilat_pkg.sv]
// Types, codes and the saturation helper function shared by the trilateration solver modules.
`timescale 1ns / 1ps

package trilat_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int RANGE_WIDTH = 16;
	localparam int POS_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
	localparam logic [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ANCHOR_A_X,
		REG_ANCHOR_A_Y,
		REG_ANCHOR_B_X,
		REG_ANCHOR_B_Y,
		REG_ANCHOR_C_X,
		REG_ANCHOR_C_Y
	} reg_index_e;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_COLLINEAR,
		STATUS_EQUAL_X,
		STATUS_SATURATED
	} status_e;

	typedef struct packed {
		logic [RANGE_WIDTH-1:0] range_a;
		logic [RANGE_WIDTH-1:0] range_b;
		logic [RANGE_WIDTH-1:0] range_c;
	} in_t;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] pos_x;
		logic signed [POS_WIDTH-1:0] pos_y;
		logic [1:0] status;
	} out_t;

	typedef struct packed {
		logic den_zero;
		logic equal_x;
	} flags_t;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] value;
		logic sat;
	} sat_t;

	// Turns a quotient magnitude, its overflow flag and its sign into a clamped signed value.
	function automatic sat_t saturate(input logic [POS_WIDTH-1:0] mag, input logic ovf,
			input logic neg);
		sat_t r;
		if (neg) begin
			if (ovf || (mag > POS_MIN)) begin
				r.value = POS_MIN;
				r.sat = 1'b1;
			end else begin
				r.value = -mag;
				r.sat = 1'b0;
			end
		end else begin
			if (ovf || mag[POS_WIDTH-1]) begin
				r.value = POS_MAX;
				r.sat = 1'b1;
			end else begin
				r.value = mag;
				r.sat = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

[rtl/trilat_front.sv]
// Front pipeline: squares, the combinations S and T, the determinant and the y numerator.
`timescale 1ns / 1ps

module trilat_front #(
	parameter int COORD_WIDTH = trilat_pkg::COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  trilat_pkg::in_t in_data,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	output logic out_valid,
	output logic [3*COORD_WIDTH+4:0] ny_mag,
	output logic [2*COORD_WIDTH+5:0] d2_mag,
	output logic neg,
	output logic signed [2*COORD_WIDTH+2:0] t_val,
	output logic signed [COORD_WIDTH:0] ayby,
	output logic signed [COORD_WIDTH:0] bxax,
	output trilat_pkg::flags_t flags
);

	localparam int CW = COORD_WIDTH;
	localparam int DFW = CW + 1;
	localparam int SQW = 2 * CW;
	localparam int SW = 2 * CW + 3;
	localparam int PW2 = 2 * DFW;
	localparam int DNW = PW2 + 1;
	localparam int MW = SW + DFW;
	localparam int NYW = MW + 1;

	logic [CW-1:0] ra, rb, rc;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [SQW-1:0] ra_sq_s1, rb_sq_s1, rc_sq_s1;
	logic [SQW-1:0] ax_sq_s1, ay_sq_s1, bx_sq_s1, by_sq_s1, cx_sq_s1, cy_sq_s1;
	logic signed [DFW-1:0] bxcx_s1, bxax_s1, ayby_s1, cyby_s1;

	logic signed [SW-1:0] s_s2, t_s2;
	logic signed [PW2-1:0] p1_s2, p2_s2;
	logic signed [DFW-1:0] bxcx_s2, bxax_s2, ayby_s2;

	logic signed [DNW-1:0] d_s3;
	logic signed [MW-1:0] mt_s3, ms_s3;
	logic signed [SW-1:0] t_s3;
	logic signed [DFW-1:0] bxax_s3, ayby_s3;

	logic signed [NYW-1:0] ny_s4;
	logic [DNW-1:0] dmag_s4;
	logic dneg_s4;
	logic signed [SW-1:0] t_s4;
	logic signed [DFW-1:0] bxax_s4, ayby_s4;
	trilat_pkg::flags_t flags_s4;

	logic [NYW-1:0] nymag_s5;
	logic [DNW:0] d2mag_s5;
	logic neg_s5;
	logic signed [SW-1:0] t_s5;
	logic signed [DFW-1:0] bxax_s5, ayby_s5;
	trilat_pkg::flags_t flags_s5;

	assign ra = CW'(in_data.range_a);
	assign rb = CW'(in_data.range_b);
	assign rc = CW'(in_data.range_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_sq_s1 <= SQW'(ra) * SQW'(ra);
			rb_sq_s1 <= SQW'(rb) * SQW'(rb);
			rc_sq_s1 <= SQW'(rc) * SQW'(rc);
			ax_sq_s1 <= SQW'(ax) * SQW'(ax);
			ay_sq_s1 <= SQW'(ay) * SQW'(ay);
			bx_sq_s1 <= SQW'(bx) * SQW'(bx);
			by_sq_s1 <= SQW'(by) * SQW'(by);
			cx_sq_s1 <= SQW'(cx) * SQW'(cx);
			cy_sq_s1 <= SQW'(cy) * SQW'(cy);
			bxcx_s1 <= DFW'(bx) - DFW'(cx);
			bxax_s1 <= DFW'(bx) - DFW'(ax);
			ayby_s1 <= DFW'(ay) - DFW'(by);
			cyby_s1 <= DFW'(cy) - DFW'(by);

			s_s2 <= SW'(cx_sq_s1) + SW'(cy_sq_s1) - SW'(bx_sq_s1) - SW'(by_sq_s1)
				+ SW'(rb_sq_s1) - SW'(rc_sq_s1);
			t_s2 <= SW'(ax_sq_s1) + SW'(ay_sq_s1) - SW'(bx_sq_s1) - SW'(by_sq_s1)
				+ SW'(rb_sq_s1) - SW'(ra_sq_s1);
			p1_s2 <= PW2'(ayby_s1) * PW2'(bxcx_s1);
			p2_s2 <= PW2'(cyby_s1) * PW2'(bxax_s1);
			bxcx_s2 <= bxcx_s1;
			bxax_s2 <= bxax_s1;
			ayby_s2 <= ayby_s1;

			d_s3 <= DNW'(p1_s2) - DNW'(p2_s2);
			mt_s3 <= MW'(t_s2) * MW'(bxcx_s2);
			ms_s3 <= MW'(s_s2) * MW'(bxax_s2);
			t_s3 <= t_s2;
			bxax_s3 <= bxax_s2;
			ayby_s3 <= ayby_s2;

			ny_s4 <= NYW'(mt_s3) - NYW'(ms_s3);
			dmag_s4 <= d_s3[DNW-1] ? -d_s3 : d_s3;
			dneg_s4 <= d_s3[DNW-1];
			flags_s4.den_zero <= (d_s3 == '0);
			flags_s4.equal_x <= (bxax_s3 == '0);
			t_s4 <= t_s3;
			bxax_s4 <= bxax_s3;
			ayby_s4 <= ayby_s3;

			nymag_s5 <= ny_s4[NYW-1] ? -ny_s4 : ny_s4;
			d2mag_s5 <= {dmag_s4, 1'b0};
			neg_s5 <= ny_s4[NYW-1] ^ dneg_s4;
			flags_s5 <= flags_s4;
			t_s5 <= t_s4;
			bxax_s5 <= bxax_s4;
			ayby_s5 <= ayby_s4;
		end
	end

	assign out_valid = v_s5;
	assign ny_mag = nymag_s5;
	assign d2_mag = d2mag_s5;
	assign neg = neg_s5;
	assign t_val = t_s5;
	assign ayby = ayby_s5;
	assign bxax = bxax_s5;
	assign flags = flags_s5;

endmodule

[rtl/trilat_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
`timescale 1ns / 1ps

module trilat_div #(
	parameter int NW = 53,
	parameter int DW = 36,
	parameter int QW = trilat_pkg::POS_WIDTH,
	parameter int PW = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] dvs,
	input  logic neg,
	input  logic [PW-1:0] pay,
	output logic out_valid,
	output logic [QW-1:0] quo,
	output logic ovf,
	output logic neg_out,
	output logic [PW-1:0] pay_out
);

	localparam int AW = (NW > DW + QW) ? NW : DW + QW;

	logic [QW:0] v_s;
	logic [QW:0] ovf_s;
	logic [QW:0] neg_s;
	logic [AW-1:0] rem_s [QW+1];
	logic [DW-1:0] dvs_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [PW-1:0] pay_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QW-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= AW'(num);
			dvs_s[0] <= dvs;
			quo_s[0] <= '0;
			ovf_s[0] <= (AW'(num) >= (AW'(dvs) << QW));
			neg_s[0] <= neg;
			pay_s[0] <= pay;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [AW-1:0] sh;
		logic ge;

		assign sh = AW'(dvs_s[k]) << B;
		assign ge = (rem_s[k] >= sh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - sh : rem_s[k];
				dvs_s[k+1] <= dvs_s[k];
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				ovf_s[k+1] <= ovf_s[k];
				neg_s[k+1] <= neg_s[k];
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];
	assign neg_out = neg_s[QW];
	assign pay_out = pay_s[QW];

endmodule

[rtl/trilat_xnum.sv]
// Middle pipeline: saturates y and forms the x numerator and divisor magnitudes.
`timescale 1ns / 1ps

module trilat_xnum #(
	parameter int COORD_WIDTH = trilat_pkg::COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic [trilat_pkg::POS_WIDTH-1:0] qmag,
	input  logic ovf,
	input  logic neg,
	input  logic signed [2*COORD_WIDTH+2:0] t_val,
	input  logic signed [COORD_WIDTH:0] ayby,
	input  logic signed [COORD_WIDTH:0] bxax,
	input  trilat_pkg::flags_t flags_in,
	output logic out_valid,
	output logic [((trilat_pkg::POS_WIDTH + COORD_WIDTH + 2 > 2 * COORD_WIDTH + 3) ?
		trilat_pkg::POS_WIDTH + COORD_WIDTH + 2 : 2 * COORD_WIDTH + 3):0] nx_mag,
	output logic [COORD_WIDTH+1:0] dx_mag,
	output logic neg_out,
	output logic signed [trilat_pkg::POS_WIDTH-1:0] py,
	output logic ysat,
	output trilat_pkg::flags_t flags
);

	localparam int PWD = trilat_pkg::POS_WIDTH;
	localparam int DFW = COORD_WIDTH + 1;
	localparam int SW = 2 * COORD_WIDTH + 3;
	localparam int PRW = PWD + DFW;
	localparam int NXW = ((PRW + 1 > SW) ? PRW + 1 : SW) + 1;

	trilat_pkg::sat_t ys;

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [PWD-1:0] py_s1, py_s2, py_s3, py_s4;
	logic ysat_s1, ysat_s2, ysat_s3, ysat_s4;
	trilat_pkg::flags_t flags_s1, flags_s2, flags_s3, flags_s4;
	logic signed [SW-1:0] t_s1, t_s2;
	logic signed [DFW-1:0] ayby_s1;
	logic signed [DFW-1:0] bxax_s1, bxax_s2, bxax_s3;
	logic signed [PRW-1:0] prod_s2;
	logic signed [NXW-1:0] nx_s3;
	logic [NXW-1:0] nxmag_s4;
	logic [DFW:0] dxmag_s4;
	logic neg_s4;

	assign ys = trilat_pkg::saturate(qmag, ovf, neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			py_s1 <= ys.value;
			ysat_s1 <= ys.sat;
			flags_s1 <= flags_in;
			t_s1 <= t_val;
			ayby_s1 <= ayby;
			bxax_s1 <= bxax;

			prod_s2 <= PRW'(py_s1) * PRW'(ayby_s1);
			py_s2 <= py_s1;
			ysat_s2 <= ysat_s1;
			flags_s2 <= flags_s1;
			t_s2 <= t_s1;
			bxax_s2 <= bxax_s1;

			nx_s3 <= (NXW'(prod_s2) << 1) - NXW'(t_s2);
			py_s3 <= py_s2;
			ysat_s3 <= ysat_s2;
			flags_s3 <= flags_s2;
			bxax_s3 <= bxax_s2;

			nxmag_s4 <= nx_s3[NXW-1] ? -nx_s3 : nx_s3;
			dxmag_s4 <= {(bxax_s3[DFW-1] ? -bxax_s3 : bxax_s3), 1'b0};
			neg_s4 <= nx_s3[NXW-1] ^ bxax_s3[DFW-1];
			py_s4 <= py_s3;
			ysat_s4 <= ysat_s3;
			flags_s4 <= flags_s3;
		end
	end

	assign out_valid = v_s4;
	assign nx_mag = nxmag_s4;
	assign dx_mag = dxmag_s4;
	assign neg_out = neg_s4;
	assign py = py_s4;
	assign ysat = ysat_s4;
	assign flags = flags_s4;

endmodule

[rtl/trilateration_solver.sv]
// Throughput: one transaction per cycle while the skid buffer is empty; a full one stalls the
// pipeline. Five front stages, two 33-stage restoring dividers (an input register, then one
// quotient bit per stage), four middle stages and the output register make up the pipeline.
// A one-entry skid buffer lets the pipeline keep moving while one result waits to be taken.
// Reset clears all valid bits and sets the six anchor registers to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trilateration_solver #(
	parameter int COORD_WIDTH = trilat_pkg::COORD_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  trilat_pkg::in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output trilat_pkg::out_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [trilat_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	localparam int CW = COORD_WIDTH;
	localparam int PWD = trilat_pkg::POS_WIDTH;
	localparam int DFW = CW + 1;
	localparam int SW = 2 * CW + 3;
	localparam int DNW = 2 * DFW + 1;
	localparam int NYW = SW + DFW + 1;
	localparam int PRW = PWD + DFW;
	localparam int NXW = ((PRW + 1 > SW) ? PRW + 1 : SW) + 1;
	localparam int YPW = SW + 2 * DFW + 2;
	localparam int XPW = PWD + 3;

	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;

	logic en;

	logic fr_valid;
	logic [NYW-1:0] fr_ny_mag;
	logic [DNW:0] fr_d2_mag;
	logic fr_neg;
	logic signed [SW-1:0] fr_t;
	logic signed [DFW-1:0] fr_ayby, fr_bxax;
	trilat_pkg::flags_t fr_flags;

	logic dy_valid;
	logic [PWD-1:0] dy_quo;
	logic dy_ovf, dy_neg;
	logic [YPW-1:0] dy_pay;
	logic signed [SW-1:0] dy_t;
	logic signed [DFW-1:0] dy_ayby, dy_bxax;
	trilat_pkg::flags_t dy_flags;

	logic xn_valid;
	logic [NXW-1:0] xn_nx_mag;
	logic [DFW:0] xn_dx_mag;
	logic xn_neg;
	logic signed [PWD-1:0] xn_py;
	logic xn_ysat;
	trilat_pkg::flags_t xn_flags;

	logic dx_valid;
	logic [PWD-1:0] dx_quo;
	logic dx_ovf, dx_neg;
	logic [XPW-1:0] dx_pay;
	logic signed [PWD-1:0] dx_py;
	logic dx_ysat;
	trilat_pkg::flags_t dx_flags;

	trilat_pkg::sat_t xs;
	trilat_pkg::out_t res;
	logic push;

	trilat_pkg::out_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				trilat_pkg::REG_ANCHOR_A_X: ax_q <= cfg_data;
				trilat_pkg::REG_ANCHOR_A_Y: ay_q <= cfg_data;
				trilat_pkg::REG_ANCHOR_B_X: bx_q <= cfg_data;
				trilat_pkg::REG_ANCHOR_B_Y: by_q <= cfg_data;
				trilat_pkg::REG_ANCHOR_C_X: cx_q <= cfg_data;
				trilat_pkg::REG_ANCHOR_C_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !skid_valid_q;
	assign in_ready = en;

	trilat_front #(
		.COORD_WIDTH(CW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.in_data(in_data),
		.ax(ax_q),
		.ay(ay_q),
		.bx(bx_q),
		.by(by_q),
		.cx(cx_q),
		.cy(cy_q),
		.out_valid(fr_valid),
		.ny_mag(fr_ny_mag),
		.d2_mag(fr_d2_mag),
		.neg(fr_neg),
		.t_val(fr_t),
		.ayby(fr_ayby),
		.bxax(fr_bxax),
		.flags(fr_flags)
	);

	trilat_div #(
		.NW(NYW),
		.DW(DNW + 1),
		.QW(PWD),
		.PW(YPW)
	) u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fr_valid),
		.num(fr_ny_mag),
		.dvs(fr_d2_mag),
		.neg(fr_neg),
		.pay({fr_t, fr_ayby, fr_bxax, fr_flags}),
		.out_valid(dy_valid),
		.quo(dy_quo),
		.ovf(dy_ovf),
		.neg_out(dy_neg),
		.pay_out(dy_pay)
	);

	assign {dy_t, dy_ayby, dy_bxax, dy_flags} = dy_pay;

	trilat_xnum #(
		.COORD_WIDTH(CW)
	) u_xnum (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(dy_valid),
		.qmag(dy_quo),
		.ovf(dy_ovf),
		.neg(dy_neg),
		.t_val(dy_t),
		.ayby(dy_ayby),
		.bxax(dy_bxax),
		.flags_in(dy_flags),
		.out_valid(xn_valid),
		.nx_mag(xn_nx_mag),
		.dx_mag(xn_dx_mag),
		.neg_out(xn_neg),
		.py(xn_py),
		.ysat(xn_ysat),
		.flags(xn_flags)
	);

	trilat_div #(
		.NW(NXW),
		.DW(DFW + 1),
		.QW(PWD),
		.PW(XPW)
	) u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(xn_valid),
		.num(xn_nx_mag),
		.dvs(xn_dx_mag),
		.neg(xn_neg),
		.pay({xn_py, xn_ysat, xn_flags}),
		.out_valid(dx_valid),
		.quo(dx_quo),
		.ovf(dx_ovf),
		.neg_out(dx_neg),
		.pay_out(dx_pay)
	);

	assign {dx_py, dx_ysat, dx_flags} = dx_pay;

	assign xs = trilat_pkg::saturate(dx_quo, dx_ovf, dx_neg);

	always_comb begin
		if (dx_flags.den_zero) begin
			res.pos_x = '0;
			res.pos_y = '0;
			res.status = trilat_pkg::STATUS_COLLINEAR;
		end else if (dx_flags.equal_x) begin
			res.pos_x = '0;
			res.pos_y = '0;
			res.status = trilat_pkg::STATUS_EQUAL_X;
		end else begin
			res.pos_x = xs.value;
			res.pos_y = dx_py;
			res.status = (dx_ysat || xs.sat) ? trilat_pkg::STATUS_SATURATED
				: trilat_pkg::STATUS_OK;
		end
	end

	assign push = en && dx_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`TRILAT_ASSERT_IMP(a_skid_needs_out, clk, arst_n, skid_valid_q, out_valid_q)
	`TRILAT_ASSERT_NEXT(a_stall_fills_skid, clk, arst_n,
		push && out_valid_q && !out_ready, skid_valid_q)
	`TRILAT_ASSERT_IMP(a_collinear_zero, clk, arst_n,
		out_valid_q && (out_q.status == trilat_pkg::STATUS_COLLINEAR),
		(out_q.pos_x == '0) && (out_q.pos_y == '0))
	`TRILAT_ASSERT_IMP(a_equal_x_zero, clk, arst_n,
		out_valid_q && (out_q.status == trilat_pkg::STATUS_EQUAL_X),
		(out_q.pos_x == '0) && (out_q.pos_y == '0))

endmodule
